[sv/mrrc_pkg.sv]
// Shared constants, types and the CRC-16 byte update for the Modbus RTU response checker.
`default_nettype none

package mrrc_pkg;

   // Largest number of bytes taken into one frame; later bytes are dropped.
   localparam int unsigned MAX_FRAME = 256;

   // Byte counter width: it must hold MAX_FRAME itself.
   localparam int unsigned IDX_W = $clog2(MAX_FRAME + 1);

   // Field widths of the channels.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned FLEN_W   = 9;
   localparam int unsigned CSR_IX_W = 2;

   // CRC-16 as used on Modbus RTU: reflected polynomial, all-ones start value.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Frame length limits used by the checks.
   localparam logic [IDX_W-1:0] MIN_FRAME_LEN   = IDX_W'(5);
   localparam logic [IDX_W-1:0] MIN_WRITE_LEN   = IDX_W'(8);
   localparam logic [IDX_W-1:0] FIRST_DATA_IDX  = IDX_W'(3);

   // Configuration register indexes.
   localparam logic [CSR_IX_W-1:0] CSR_SLAVE_ADDRESS     = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_EXPECTED_FUNCTION = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_PARSE_MODE        = 2'd2;

   // Parse modes.
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Frame status codes.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TIMEOUT   = 3'd1,
      STATUS_INVALID   = 3'd2,
      STATUS_CRC_ERROR = 3'd3,
      STATUS_EXCEPTION = 3'd4
   } status_type;

   // One byte through the reflected CRC-16, bit by bit.
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc_prev,
                                              input logic [7:0]  data_byte);
      logic [15:0] crc;
      crc = crc_prev ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

[sv/mrrc_if.sv]
// Valid/ready channel interfaces for received bytes, results and register writes.
`default_nettype none

interface mrrc_req_if import mrrc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              last_byte;
   logic              no_response;

   modport source (output valid, output rx_byte, output last_byte, output no_response,
                   input ready);
   modport sink (input valid, input rx_byte, input last_byte, input no_response,
                 output ready);
endinterface

interface mrrc_rsp_if import mrrc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              data_valid;
   logic              frame_done;
   status_type        status;
   logic [BYTE_W-1:0] exc_code;
   logic [BYTE_W-1:0] payload_count;
   logic [FLEN_W-1:0] frame_length;

   modport source (output valid, output data_byte, output data_valid, output frame_done,
                   output status, output exc_code, output payload_count,
                   output frame_length, input ready);
   modport sink (input valid, input data_byte, input data_valid, input frame_done,
                 input status, input exc_code, input payload_count,
                 input frame_length, output ready);
endinterface

interface mrrc_csr_if import mrrc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CSR_IX_W-1:0] index;
   logic [BYTE_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[sv/modbus_rtu_response_checker_unit.sv]
// Top level of the Modbus RTU response checker: frame state, checks and result register.
//
// The block takes one response byte per clock and gives one result per byte from a result
// register in the next cycle. It accepts a new byte in every cycle in which the result
// register is empty or its result is being taken, so a steady stream runs at one byte per
// cycle. That figure is set by the byte-wide CRC-16 update and the closing checks, which
// together sit between the frame state and the result register. A timeout transfer ends
// the frame at once; bytes beyond the maximum frame size are counted out but still close
// the frame on their last-byte flag. Register writes are taken at any time and there is
// no clearing pass after reset.
`default_nettype none

module modbus_rtu_response_checker_unit import mrrc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mrrc_req_if.sink   req_ch,
   mrrc_rsp_if.source rsp_ch,
   mrrc_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [7:0] slave_address_ff;
   logic [6:0] expected_function_ff;
   logic       parse_mode_ff;

   // Frame state.
   logic [15:0]      crc_ff,  crc_in;
   logic [7:0]       dly0_ff, dly0_in;
   logic [7:0]       dly1_ff, dly1_in;
   logic [IDX_W-1:0] idx_ff,  idx_in;
   logic [7:0]       hdr_ff [3];
   logic [7:0]       hdr_in [3];

   // Result register.
   logic              rsp_valid_ff;
   logic [7:0]        data_byte_ff, data_byte_in;
   logic              data_valid_ff, data_valid_in;
   logic              frame_done_ff, frame_done_in;
   status_type        status_ff, status_in;
   logic [7:0]        exc_ff, exc_in;
   logic [7:0]        pcount_ff, pcount_in;
   logic [FLEN_W-1:0] flen_ff, flen_in;

   logic accept;
   logic in_range;

   // Values after taking this byte, before a closing clear.
   logic [15:0]      crc_nx;
   logic [7:0]       dly0_nx, dly1_nx;
   logic [IDX_W-1:0] idx_nx;
   logic [7:0]       hdr_nx [3];
   status_type       judged;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_range     = idx_ff < IDX_W'(MAX_FRAME);

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff     <= 8'd1;
         expected_function_ff <= 7'd3;
         parse_mode_ff        <= MODE_READ;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_SLAVE_ADDRESS:     slave_address_ff     <= csr_ch.wdata;
            CSR_EXPECTED_FUNCTION: expected_function_ff <= csr_ch.wdata[6:0];
            CSR_PARSE_MODE:        parse_mode_ff        <= csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   // Take the byte into the CRC delay line, the header and the counter.
   always_comb begin
      crc_nx  = crc_ff;
      dly0_nx = dly0_ff;
      dly1_nx = dly1_ff;
      idx_nx  = idx_ff;
      for (int h = 0; h < 3; h++) begin
         hdr_nx[h] = hdr_ff[h];
      end
      if (in_range) begin
         if (idx_ff >= IDX_W'(2)) begin
            crc_nx = crc16_feed(crc_ff, dly0_ff);
         end
         dly0_nx = dly1_ff;
         dly1_nx = req_ch.rx_byte;
         for (int h = 0; h < 3; h++) begin
            if (idx_ff == IDX_W'(h)) begin
               hdr_nx[h] = req_ch.rx_byte;
            end
         end
         idx_nx = idx_ff + IDX_W'(1);
      end
   end

   // Closing checks, in priority order.
   always_comb begin
      priority if (idx_nx < MIN_FRAME_LEN) begin
         judged = STATUS_INVALID;
      end else if ({dly1_nx, dly0_nx} != crc_nx) begin
         judged = STATUS_CRC_ERROR;
      end else if (parse_mode_ff == MODE_WRITE && idx_nx < MIN_WRITE_LEN) begin
         judged = STATUS_INVALID;
      end else if (hdr_nx[0] != slave_address_ff) begin
         judged = STATUS_INVALID;
      end else if (hdr_nx[1][7]) begin
         judged = STATUS_EXCEPTION;
      end else if (hdr_nx[1][6:0] != expected_function_ff) begin
         judged = STATUS_INVALID;
      end else if (parse_mode_ff == MODE_READ &&
                   {1'b0, idx_nx} < ({1'b0, MIN_FRAME_LEN} + (IDX_W + 1)'(hdr_nx[2]))) begin
         judged = STATUS_INVALID;
      end else begin
         judged = STATUS_OK;
      end
   end

   // Next frame state and result for this transfer.
   always_comb begin
      logic close;
      close = req_ch.no_response || req_ch.last_byte;

      crc_in  = crc_nx;
      dly0_in = dly0_nx;
      dly1_in = dly1_nx;
      idx_in  = idx_nx;
      for (int h = 0; h < 3; h++) begin
         hdr_in[h] = hdr_nx[h];
      end
      if (close) begin
         crc_in  = CRC_INIT;
         dly0_in = '0;
         dly1_in = '0;
         idx_in  = '0;
         for (int h = 0; h < 3; h++) begin
            hdr_in[h] = '0;
         end
      end

      data_byte_in  = '0;
      data_valid_in = 1'b0;
      frame_done_in = close;
      status_in     = STATUS_OK;
      exc_in        = '0;
      pcount_in     = '0;
      flen_in       = FLEN_W'(idx_nx);

      if (req_ch.no_response) begin
         status_in = STATUS_TIMEOUT;
         flen_in   = FLEN_W'(idx_ff);
      end else begin
         // Payload bytes follow the byte count in read mode.
         if (in_range && parse_mode_ff == MODE_READ && idx_ff >= FIRST_DATA_IDX &&
             {1'b0, idx_ff} < ({1'b0, FIRST_DATA_IDX} + (IDX_W + 1)'(hdr_ff[2]))) begin
            data_valid_in = 1'b1;
            data_byte_in  = req_ch.rx_byte;
         end
         if (req_ch.last_byte) begin
            status_in = judged;
            if (judged == STATUS_EXCEPTION) begin
               exc_in = hdr_nx[2];
            end
            if (judged == STATUS_OK && parse_mode_ff == MODE_READ) begin
               pcount_in = hdr_nx[2];
            end
         end
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         dly0_ff <= '0;
         dly1_ff <= '0;
         idx_ff  <= '0;
         for (int h = 0; h < 3; h++) begin
            hdr_ff[h] <= '0;
         end
      end else if (accept) begin
         crc_ff  <= crc_in;
         dly0_ff <= dly0_in;
         dly1_ff <= dly1_in;
         idx_ff  <= idx_in;
         for (int h = 0; h < 3; h++) begin
            hdr_ff[h] <= hdr_in[h];
         end
      end
   end

   // Result register: loaded on each input transfer, freed on an output transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_byte_ff  <= data_byte_in;
         data_valid_ff <= data_valid_in;
         frame_done_ff <= frame_done_in;
         status_ff     <= status_in;
         exc_ff        <= exc_in;
         pcount_ff     <= pcount_in;
         flen_ff       <= flen_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.data_byte      = data_byte_ff;
   assign rsp_ch.data_valid     = data_valid_ff;
   assign rsp_ch.frame_done     = frame_done_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.exc_code       = exc_ff;
   assign rsp_ch.payload_count  = pcount_ff;
   assign rsp_ch.frame_length   = flen_ff;

   // A timeout transfer leaves an empty frame behind.
   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.no_response |=> idx_ff == '0 && crc_ff == CRC_INIT)
      else $error("frame state not cleared after timeout");

   // The byte counter never passes the frame limit.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(MAX_FRAME))
      else $error("byte counter beyond frame limit");

   // An empty result register never stalls the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty result register");

   // Results that do not close a frame carry no status.
   a_status_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !frame_done_ff |-> status_ff == STATUS_OK && exc_ff == '0)
      else $error("status reported on an open frame");

   // Payload bytes come only after the three header bytes.
   a_data_after_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && data_valid_ff |-> flen_ff >= FLEN_W'(4))
      else $error("payload byte flagged inside header");

endmodule

`default_nettype wire
